// File: rtl/mclp_pkg.sv
// shared types and character codes for the motor command line parser
package mclp_pkg;

    localparam logic [7:0] CHR_HASH   = 8'h23;
    localparam logic [7:0] CHR_M      = 8'h4D;
    localparam logic [7:0] CHR_R      = 8'h52;
    localparam logic [7:0] CHR_EQUALS = 8'h3D;
    localparam logic [7:0] CHR_COMMA  = 8'h2C;
    localparam logic [7:0] CHR_PLUS   = 8'h2B;
    localparam logic [7:0] CHR_MINUS  = 8'h2D;
    localparam logic [7:0] CHR_SPACE  = 8'h20;
    localparam logic [7:0] CHR_TAB    = 8'h09;
    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CHR_NINE   = 8'h39;

    localparam logic [15:0] TIMEOUT_MS_RESET      = 16'd1000;
    localparam logic [7:0]  LINE_TERMINATOR_RESET = CHR_HASH;

    localparam logic REG_TIMEOUT_MS      = 1'b0;
    localparam logic REG_LINE_TERMINATOR = 1'b1;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] thrust;
        logic signed [15:0] rudder;
        logic               cmd_fresh;
        logic               motor_update;
        logic               radio_valid;
        logic               radio_select;
        logic [15:0]        bad_parse_count;
        logic [15:0]        motor_command_count;
    } out_item_t;

endpackage

// File: rtl/motor_command_line_parser.sv
// motor command line parser: byte-wise command decoder with timeout tracking
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+--------------------------
//  s_        | in        | s_valid / s_ready         | s_item  (op, byte_value)
//  m_        | out       | m_valid / m_ready         | m_item  (one result per item)
//  cfg_      | in        | cfg_wr_en, no wait        | cfg_index, cfg_wdata
//
// every item gives exactly one result; an accepted item waits in the input register
// and is loaded into the result register once the result slot is free
// one item per cycle sustained while m_ready holds: input register -> parse logic -> result register
// the parse state, accumulator and counters update as an item moves to the result register
// reset (aresetn low, synchronous) clears the parse state, counters and commands
// and reloads the config reset values
// a stalled result register holds the item in the input register, then drops s_ready
module motor_command_line_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mclp_pkg::in_item_t s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output mclp_pkg::out_item_t m_item,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_wdata
);
    import mclp_pkg::*;

    // parse state codes; the number phases sit at base + phase
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_GOT_M  = 4'd1;
    localparam logic [3:0] ST_GOT_R  = 4'd2;
    localparam logic [3:0] ST_BAD    = 4'd3;
    localparam logic [3:0] ST_M1_WS  = 4'd4;
    localparam logic [3:0] ST_M1_SGN = 4'd5;
    localparam logic [3:0] ST_M1_DIG = 4'd6;
    localparam logic [3:0] ST_M2_WS  = 4'd7;
    localparam logic [3:0] ST_M2_SGN = 4'd8;
    localparam logic [3:0] ST_M2_DIG = 4'd9;
    localparam logic [3:0] ST_MREST  = 4'd10;
    localparam logic [3:0] ST_R_WS   = 4'd11;
    localparam logic [3:0] ST_R_SGN  = 4'd12;
    localparam logic [3:0] ST_R_DIG  = 4'd13;
    localparam logic [3:0] ST_RREST  = 4'd14;

    // number scan phases
    localparam logic [2:0] PH_WS   = 3'd0;
    localparam logic [2:0] PH_SGN  = 3'd1;
    localparam logic [2:0] PH_DIG  = 3'd2;
    localparam logic [2:0] PH_OK   = 3'd3;
    localparam logic [2:0] PH_FAIL = 3'd4;

    localparam logic [15:0] MAG_LIMIT = 16'h8000;
    localparam logic [15:0] POS_LIMIT = 16'h7FFF;
    localparam logic [15:0] AGE_MAX   = 16'hFFFF;

    // config registers
    logic [15:0] timeout_reg;
    logic [7:0]  term_reg;

    // input stage
    logic     in_vld_reg;
    in_item_t in_item_reg;

    // result stage
    logic      out_vld_reg;
    out_item_t out_item_reg;

    // parser state
    logic [3:0]  state_reg,  state_next;
    logic [15:0] acc_reg,    acc_next;
    logic        neg_reg,    neg_next;
    logic [15:0] pfirst_reg, pfirst_next;
    logic [1:0]  pflags_reg, pflags_next;
    logic [15:0] thrust_reg, thrust_next;
    logic [15:0] rudder_reg, rudder_next;
    logic [15:0] age_reg,    age_next;
    logic [15:0] bad_reg,    bad_next;
    logic [15:0] mcnt_reg,   mcnt_next;

    logic motor_upd, radio_vld, radio_sel;

    logic       adv;
    logic [7:0] b;
    logic       is_term, is_digit, is_ws;
    logic       in_m1, in_m2;
    logic [3:0] phase_off;
    logic [1:0] phase;
    logic [2:0] nres;
    logic [15:0] nacc;
    logic        nneg;
    logic [19:0] prod;
    logic [15:0] numval;
    logic [1:0]  tflags;

    // item moves from input to result register when the result slot is free
    assign adv     = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || adv;
    assign m_valid = out_vld_reg;
    assign m_item  = out_item_reg;

    assign b        = in_item_reg.byte_value;
    assign is_term  = (b == term_reg);
    assign is_digit = (b >= CHR_ZERO) && (b <= CHR_NINE);
    assign is_ws    = (b == CHR_SPACE) || ((b >= CHR_TAB) && (b <= CHR_CR));

    assign in_m1 = (state_reg >= ST_M1_WS) && (state_reg <= ST_M1_DIG);
    assign in_m2 = (state_reg >= ST_M2_WS) && (state_reg <= ST_M2_DIG);

    always_comb begin
        if (in_m1) begin
            phase_off = state_reg - ST_M1_WS;
        end else if (in_m2) begin
            phase_off = state_reg - ST_M2_WS;
        end else begin
            phase_off = state_reg - ST_R_WS;
        end
    end
    assign phase = phase_off[1:0];

    // acc * 10 + digit as shift-add; acc never exceeds 32768
    assign prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {16'd0, b[3:0]};

    // signed value of the number so far, saturated to 16 bits
    assign numval = neg_reg ? (16'd0 - acc_reg) : (acc_reg[15] ? POS_LIMIT : acc_reg);

    // one step of the number scanner
    always_comb begin
        nacc = acc_reg;
        nneg = neg_reg;
        if (is_digit) begin
            nacc = (prod > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : prod[15:0];
            nres = PH_DIG;
        end else if (phase == PH_WS[1:0]) begin
            priority if (is_ws) begin
                nres = PH_WS;
            end else if (b == CHR_PLUS) begin
                nres = PH_SGN;
            end else if (b == CHR_MINUS) begin
                nneg = 1'b1;
                nres = PH_SGN;
            end else begin
                nres = PH_FAIL;
            end
        end else if (phase == PH_DIG[1:0]) begin
            nres = PH_OK;
        end else begin
            nres = PH_FAIL;
        end
    end

    // next parser state for the item in the input register
    always_comb begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        pfirst_next = pfirst_reg;
        pflags_next = pflags_reg;
        thrust_next = thrust_reg;
        rudder_next = rudder_reg;
        age_next    = age_reg;
        bad_next    = bad_reg;
        mcnt_next   = mcnt_reg;
        motor_upd   = 1'b0;
        radio_vld   = 1'b0;
        radio_sel   = 1'b0;
        tflags      = pflags_reg;

        if (in_item_reg.op == OP_TICK) begin
            // saturating millisecond age
            if (age_reg != AGE_MAX) begin
                age_next = age_reg + 16'd1;
            end
        end else if (is_term) begin
            // terminator closes the line in every state
            priority if (state_reg == ST_GOT_M || state_reg == ST_GOT_R
                         || state_reg == ST_BAD) begin
                bad_next = bad_reg + 16'd1;
            end else if (state_reg >= ST_M1_WS && state_reg <= ST_MREST) begin
                tflags = pflags_reg;
                if (state_reg == ST_M1_DIG) begin
                    pfirst_next = numval;
                    tflags[0]   = 1'b1;
                end
                if (state_reg == ST_M2_DIG) begin
                    tflags[1] = 1'b1;
                end
                if (tflags[0]) begin
                    thrust_next = pfirst_next;
                end
                if (tflags[1]) begin
                    rudder_next = numval;
                end
                age_next  = 16'd0;
                mcnt_next = mcnt_reg + 16'd1;
                motor_upd = 1'b1;
            end else if (state_reg >= ST_R_WS && state_reg <= ST_RREST) begin
                if (pflags_reg[0] || state_reg == ST_R_DIG) begin
                    radio_vld = 1'b1;
                    radio_sel = (numval != 16'd0);
                end
            end else begin
                // idle and unused codes: terminator skipped
            end
            state_next  = ST_IDLE;
            pflags_next = 2'b00;
        end else begin
            unique case (state_reg)
                ST_GOT_M, ST_GOT_R: begin
                    if (b == CHR_EQUALS) begin
                        acc_next    = 16'd0;
                        neg_next    = 1'b0;
                        pflags_next = 2'b00;
                        state_next  = (state_reg == ST_GOT_M) ? ST_M1_WS : ST_R_WS;
                    end else begin
                        state_next = ST_BAD;
                    end
                end
                ST_M1_WS, ST_M1_SGN, ST_M1_DIG: begin
                    acc_next = nacc;
                    neg_next = nneg;
                    priority if (nres < PH_OK) begin
                        state_next = ST_M1_WS + {2'b00, nres[1:0]};
                    end else if (nres == PH_OK) begin
                        pfirst_next    = numval;
                        pflags_next[0] = 1'b1;
                        if (b == CHR_COMMA) begin
                            acc_next   = 16'd0;
                            neg_next   = 1'b0;
                            state_next = ST_M2_WS;
                        end else begin
                            state_next = ST_MREST;
                        end
                    end else begin
                        state_next = ST_MREST;
                    end
                end
                ST_M2_WS, ST_M2_SGN, ST_M2_DIG: begin
                    acc_next = nacc;
                    neg_next = nneg;
                    if (nres < PH_OK) begin
                        state_next = ST_M2_WS + {2'b00, nres[1:0]};
                    end else begin
                        if (nres == PH_OK) begin
                            pflags_next[1] = 1'b1;
                        end
                        state_next = ST_MREST;
                    end
                end
                ST_R_WS, ST_R_SGN, ST_R_DIG: begin
                    acc_next = nacc;
                    neg_next = nneg;
                    if (nres < PH_OK) begin
                        state_next = ST_R_WS + {2'b00, nres[1:0]};
                    end else begin
                        if (nres == PH_OK) begin
                            pflags_next[0] = 1'b1;
                        end
                        state_next = ST_RREST;
                    end
                end
                ST_BAD, ST_MREST, ST_RREST: begin
                    // skip to terminator
                end
                default: begin
                    // idle and unused codes look for a command letter
                    if (b == CHR_M) begin
                        state_next = ST_GOT_M;
                    end else if (b == CHR_R) begin
                        state_next = ST_GOT_R;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            endcase
        end
    end

    // config port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_MS_RESET;
            term_reg    <= LINE_TERMINATOR_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TIMEOUT_MS:      timeout_reg <= cfg_wdata;
                REG_LINE_TERMINATOR: term_reg    <= cfg_wdata[7:0];
                default:             timeout_reg <= timeout_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
    end

    // parser state and counters advance with the item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            acc_reg    <= 16'd0;
            neg_reg    <= 1'b0;
            pfirst_reg <= 16'd0;
            pflags_reg <= 2'b00;
            thrust_reg <= 16'd0;
            rudder_reg <= 16'd0;
            age_reg    <= 16'd0;
            bad_reg    <= 16'd0;
            mcnt_reg   <= 16'd0;
        end else if (adv) begin
            state_reg  <= state_next;
            acc_reg    <= acc_next;
            neg_reg    <= neg_next;
            pfirst_reg <= pfirst_next;
            pflags_reg <= pflags_next;
            thrust_reg <= thrust_next;
            rudder_reg <= rudder_next;
            age_reg    <= age_next;
            bad_reg    <= bad_next;
            mcnt_reg   <= mcnt_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
        if (adv) begin
            out_item_reg.thrust              <= thrust_next;
            out_item_reg.rudder              <= rudder_next;
            out_item_reg.cmd_fresh           <= (age_next <= timeout_reg);
            out_item_reg.motor_update        <= motor_upd;
            out_item_reg.radio_valid         <= radio_vld;
            out_item_reg.radio_select        <= radio_sel;
            out_item_reg.bad_parse_count     <= bad_next;
            out_item_reg.motor_command_count <= mcnt_next;
        end
    end

endmodule
